// ===== hdl/i2c_memory_address_pointer_defines.svh =====
// Assertion macros for the I2C memory address pointer block.
// Taken in by the top level; no other dependencies.

`ifndef I2C_MEMORY_ADDRESS_POINTER_DEFINES_SVH
`define I2C_MEMORY_ADDRESS_POINTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define I2CMAP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define I2CMAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/i2cmap_pkg.sv =====
// Shared types, constants and helpers for the I2C memory address pointer.
// No dependencies; imported by every module of the block except the RAM.

package i2cmap_pkg;

    // Store geometry
    localparam int MEM_DEPTH = 65536;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    // Pointer and size widths (fixed by the bus protocol)
    localparam int PTR_W     = 16;
    localparam int SIZE_W    = 17;
    localparam int CNT_W     = $clog2(PTR_W);
    localparam int SIZE_MAX  = 65536;
    localparam int ONE_BYTE_LIMIT = 256;

    // Bus events from the slave engine
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_RECV  = 2'd1,
        OP_SEND  = 2'd2,
        OP_STOP  = 2'd3
    } t_op;

    // Transfer phase: two address phases, then data
    typedef enum logic [1:0] {
        PH_ADDR_HI = 2'd0,
        PH_ADDR_LO = 2'd1,
        PH_DATA    = 2'd2,
        PH_STOPPED = 2'd3
    } t_phase;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIVIDE,
        ST_ACCESS,
        ST_READ_OUT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic clr_step;
        logic start_xfer;
        logic stop_xfer;
        logic addr_byte;
        logic div_start;
        logic div_step;
        logic acc_wr;
        logic acc_rd;
        logic out_load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic phase_addr;
        logic div_last;
        logic out_free;
        logic slot_ok;
    } t_status;

    // Clamp the size register to 1..SIZE_MAX, then to the store depth
    function automatic logic [SIZE_W-1:0] f_eff_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] s;
        s = v;
        if (s == '0) s = SIZE_W'(1);
        if (s > SIZE_W'(SIZE_MAX)) s = SIZE_W'(SIZE_MAX);
        if (s > SIZE_W'(MEM_DEPTH)) s = SIZE_W'(MEM_DEPTH);
        return s;
    endfunction

endpackage

// ===== hdl/i2cmap_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.

module i2cmap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/i2cmap_dp.sv =====
// Datapath: size register, phase, pointer, remainder unit, store and output word.
// Depends on i2cmap_pkg and i2cmap_ram.

module i2cmap_dp import i2cmap_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [SIZE_W-1:0] i_cfg_mem_size,
    input  logic [7:0]        i_data,
    input  logic              i_out_stall,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    output logic              o_out_valid,
    output logic [7:0]        o_read_data
);

    logic [SIZE_W-1:0] r_size,     n_size;
    t_phase            r_phase,    n_phase;
    logic [PTR_W-1:0]  r_ptr,      n_ptr;
    logic [SIZE_W-1:0] r_rem,      n_rem;
    logic [PTR_W-1:0]  r_dvd,      n_dvd;
    logic [CNT_W-1:0]  r_cnt,      n_cnt;
    logic [7:0]        r_wdata,    n_wdata;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_data,  n_out_data;

    logic              w_two_byte;
    logic [SIZE_W-1:0] w_shift;
    logic [SIZE_W:0]   w_sub;
    logic [PTR_W-1:0]  w_slot;
    logic [SIZE_W-1:0] w_next;
    logic              w_out_free;
    logic              w_ram_we;
    logic [ADDR_W-1:0] w_ram_waddr;
    logic [7:0]        w_ram_wdata;
    logic [7:0]        w_ram_rdata;

    assign w_two_byte = (r_size > SIZE_W'(ONE_BYTE_LIMIT));

    // Restoring remainder: one dividend bit per step
    assign w_shift = {r_rem[SIZE_W-2:0], r_dvd[PTR_W-1]};
    assign w_sub   = {1'b0, w_shift} - {1'b0, r_size};

    // Reduced pointer and its successor
    assign w_slot = r_rem[PTR_W-1:0];
    assign w_next = {1'b0, w_slot} + SIZE_W'(1);

    assign w_out_free = !r_out_valid || !i_out_stall;

    // Size register
    always_comb begin
        n_size = r_size;
        if (i_cfg_valid) begin
            n_size = f_eff_size(i_cfg_mem_size);
        end
    end

    // Phase and pointer
    always_comb begin
        n_phase = r_phase;
        n_ptr   = r_ptr;
        if (i_cmd.start_xfer) begin
            n_phase = w_two_byte ? PH_ADDR_HI : PH_ADDR_LO;
        end else if (i_cmd.stop_xfer) begin
            n_phase = PH_STOPPED;
        end else if (i_cmd.addr_byte) begin
            if (r_phase == PH_ADDR_HI) begin
                n_phase = PH_ADDR_LO;
                n_ptr   = {i_data, 8'h00};
            end else begin
                n_phase = PH_DATA;
                n_ptr   = w_two_byte ? (r_ptr + PTR_W'(i_data)) : PTR_W'(i_data);
            end
        end else if (i_cmd.acc_wr || i_cmd.acc_rd) begin
            n_ptr = (w_next >= r_size) ? '0 : w_next[PTR_W-1:0];
        end
    end

    // Remainder unit
    always_comb begin
        n_rem   = r_rem;
        n_dvd   = r_dvd;
        n_cnt   = r_cnt;
        n_wdata = r_wdata;
        if (i_cmd.div_start) begin
            n_rem   = '0;
            n_dvd   = r_ptr;
            n_cnt   = '0;
            n_wdata = i_data;
        end else if (i_cmd.div_step) begin
            n_rem = w_sub[SIZE_W] ? w_shift : w_sub[SIZE_W-1:0];
            n_dvd = {r_dvd[PTR_W-2:0], 1'b0};
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    // Clearing sweep address
    always_comb begin
        n_clr_addr = r_clr_addr;
        if (i_cmd.clr_step) begin
            n_clr_addr = r_clr_addr + ADDR_W'(1);
        end
    end

    // Output word
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
            n_out_data  = w_ram_rdata;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= f_eff_size(SIZE_W'(SIZE_MAX));
            r_phase     <= PH_STOPPED;
            r_ptr       <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_size      <= n_size;
            r_phase     <= n_phase;
            r_ptr       <= n_ptr;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_dvd      <= n_dvd;
        r_cnt      <= n_cnt;
        r_wdata    <= n_wdata;
        r_out_data <= n_out_data;
    end

    // Byte store: clearing sweep or data write, read at the reduced pointer
    assign w_ram_we    = i_cmd.clr_step || i_cmd.acc_wr;
    assign w_ram_waddr = i_cmd.clr_step ? r_clr_addr : w_slot[ADDR_W-1:0];
    assign w_ram_wdata = i_cmd.clr_step ? 8'h00 : r_wdata;

    i2cmap_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (i_cmd.acc_rd),
        .i_raddr (w_slot[ADDR_W-1:0]),
        .o_rdata (w_ram_rdata)
    );

    // Status back to the controller
    assign o_status.clr_last   = &r_clr_addr;
    assign o_status.phase_addr = (r_phase == PH_ADDR_HI) || (r_phase == PH_ADDR_LO);
    assign o_status.div_last   = (r_cnt == CNT_W'(PTR_W - 1));
    assign o_status.out_free   = w_out_free;
    assign o_status.slot_ok    = (r_rem < r_size);

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

endmodule

// ===== hdl/i2cmap_ctrl.sv =====
// Controller: clearing sweep, event decode and sequencing of each access.
// Depends on i2cmap_pkg.

module i2cmap_ctrl import i2cmap_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_op,
    input  t_status    i_status,
    output logic       o_in_stall,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    logic   r_is_read, n_is_read;
    t_op    w_op;

    assign w_op = t_op'(i_op);

    // Next state
    always_comb begin
        n_state   = r_state;
        n_is_read = r_is_read;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_is_read = (w_op == OP_SEND);
                    unique case (w_op) inside
                        OP_START, OP_STOP: n_state = ST_IDLE;
                        OP_RECV: begin
                            if (!i_status.phase_addr) n_state = ST_DIVIDE;
                        end
                        OP_SEND: n_state = ST_DIVIDE;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_DIVIDE: begin
                if (i_status.div_last) n_state = ST_ACCESS;
            end
            ST_ACCESS: begin
                n_state = r_is_read ? ST_READ_OUT : ST_IDLE;
            end
            ST_READ_OUT: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_CLEAR: o_cmd.clr_step = 1'b1;
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (w_op)
                        OP_START: o_cmd.start_xfer = 1'b1;
                        OP_STOP:  o_cmd.stop_xfer  = 1'b1;
                        OP_RECV: begin
                            o_cmd.addr_byte = i_status.phase_addr;
                            o_cmd.div_start = !i_status.phase_addr;
                        end
                        OP_SEND:  o_cmd.div_start  = 1'b1;
                        default:  o_cmd            = '0;
                    endcase
                end
            end
            ST_DIVIDE: o_cmd.div_step = 1'b1;
            ST_ACCESS: begin
                o_cmd.acc_wr = !r_is_read;
                o_cmd.acc_rd = r_is_read;
            end
            ST_READ_OUT: o_cmd.out_load = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_is_read <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_is_read <= n_is_read;
        end
    end

endmodule

// ===== hdl/i2c_memory_address_pointer.sv =====
// Top level of the I2C memory address pointer: controller plus datapath.
// Depends on i2cmap_pkg, i2cmap_ctrl, i2cmap_dp and the defines header.
//
// Byte side of an I2C serial memory. Each input word is one bus event from
// the slave engine (start of write, received byte, byte request, stop).
// After reset the store is swept to zero, one byte a cycle; input is stalled
// meanwhile, but size writes are taken at any time. Start, stop and address
// bytes are handled in the idle state that accepts them. A data byte passes
// through the accepting idle state, the bit-serial remainder unit that reduces
// the pointer modulo the size one bit per step, and one store access; a byte
// request adds a last step that moves the read word into the output register;
// that step repeats while the output register still holds a stalled word.
// The output register lets the next event be accepted while a read byte
// still waits to be taken.

`include "i2c_memory_address_pointer_defines.svh"

module i2c_memory_address_pointer import i2cmap_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // event input
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_op,
    input  logic [7:0]        i_data,
    // read byte output
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_read_data,
    // size register write
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SIZE_W-1:0] i_cfg_mem_size
);

    t_cmd    w_cmd;
    t_status w_status;

    // Size register is always writable
    assign o_cfg_ready = 1'b1;

    i2cmap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    i2cmap_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid && o_cfg_ready),
        .i_cfg_mem_size (i_cfg_mem_size),
        .i_data         (i_data),
        .i_out_stall    (i_out_stall),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_out_valid    (o_out_valid),
        .o_read_data    (o_read_data)
    );

    // Checks
    `I2CMAP_ASSERT_NOW(a_clear_stalls_input, i_clk, i_rst_n,
        w_cmd.clr_step, o_in_stall, "input taken during clearing sweep")
    `I2CMAP_ASSERT_NOW(a_slot_in_range, i_clk, i_rst_n,
        w_cmd.acc_wr || w_cmd.acc_rd, w_status.slot_ok, "reduced pointer not below size")
    `I2CMAP_ASSERT_NEXT(a_load_shows_word, i_clk, i_rst_n,
        w_cmd.out_load, o_out_valid, "loaded read byte not presented")

endmodule

// ===== dv/i2c_memory_address_pointer_checker.sv =====
// Checker for the I2C memory address pointer: tracks events, size writes and read bytes.
// Keeps its own image of the byte store and pointer; depends on i2cmap_pkg.
`timescale 1ns / 100ps

module i2c_memory_address_pointer_checker import i2cmap_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [1:0]        i_op,
    input  logic [7:0]        i_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [7:0]        i_read_data,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [SIZE_W-1:0] i_cfg_mem_size,
    output int                o_errors,
    output int                o_pending
);

    // Image of the block's state
    logic [7:0]        mem_image [MEM_DEPTH];
    logic [PTR_W-1:0]  ptr_image;
    t_phase            phase_image;
    logic [SIZE_W-1:0] size_reg;

    // Read bytes still to come out, oldest first
    logic [7:0]        read_bytes_due [$];
    int                mismatch_count;

    initial begin
        mismatch_count = 0;
    end

    // One line per mismatch, and count it
    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("ERROR %0t: %s: expected %02h, got %02h", $realtime, what, want, got);
        mismatch_count++;
    endtask

    // Size register clamped to 1..65536, then to the store depth
    function automatic int unsigned span_of(input logic [SIZE_W-1:0] r);
        int unsigned s;
        s = r;
        if (s == 0) s = 1;
        if (s > 65536) s = 65536;
        if (s > MEM_DEPTH) s = MEM_DEPTH;
        return s;
    endfunction

    // Reduce the pointer to a slot, then step it with wrap to zero
    function automatic int unsigned take_slot(input int unsigned span);
        int unsigned slot;
        int unsigned nxt;
        slot = ptr_image % span;
        nxt  = slot + 1;
        ptr_image = (nxt >= span) ? '0 : PTR_W'(nxt);
        return slot;
    endfunction

    // Apply one bus event to the image; queue a byte for a request
    task automatic apply_event(input t_op op, input logic [7:0] d);
        int unsigned span;
        int unsigned slot;
        span = span_of(size_reg);
        case (op)
            OP_START: begin
                phase_image = (span > ONE_BYTE_LIMIT) ? PH_ADDR_HI : PH_ADDR_LO;
            end
            OP_RECV: begin
                if (phase_image == PH_ADDR_HI) begin
                    phase_image = PH_ADDR_LO;
                    ptr_image   = {d, 8'h00};
                end else if (phase_image == PH_ADDR_LO) begin
                    phase_image = PH_DATA;
                    // two-byte mode adds the low byte, wrapping at 16 bits
                    if (span > ONE_BYTE_LIMIT)
                        ptr_image = ptr_image + PTR_W'(d);
                    else
                        ptr_image = PTR_W'(d);
                end else begin
                    slot = take_slot(span);
                    mem_image[slot] = d;
                end
            end
            OP_SEND: begin
                slot = take_slot(span);
                read_bytes_due.push_back(mem_image[slot]);
            end
            default: begin
                phase_image = PH_STOPPED;
            end
        endcase
    endtask

    // Monitor: output side first, since a byte never leaves in its own event's cycle
    always @(posedge i_clk) begin
        logic [7:0] want;
        if (!i_rst_n) begin
            for (int i = 0; i < MEM_DEPTH; i++) mem_image[i] = 8'h00;
            ptr_image   = '0;
            phase_image = PH_STOPPED;
            size_reg    = SIZE_W'(SIZE_MAX);
            read_bytes_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (read_bytes_due.size() == 0) begin
                    report_mismatch("read word with nothing due", 8'h00, i_read_data);
                end else begin
                    want = read_bytes_due.pop_front();
                    if (i_read_data !== want)
                        report_mismatch("read_data", want, i_read_data);
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                size_reg = i_cfg_mem_size;
            if (i_in_valid && !i_in_stall)
                apply_event(t_op'(i_op), i_data);
        end
        o_pending <= read_bytes_due.size();
        o_errors  <= mismatch_count;
    end

endmodule

// ===== dv/i2c_memory_address_pointer_tb.sv =====
// Testbench top for the I2C memory address pointer: clock, reset, stimulus and verdict.
// Depends on i2cmap_pkg, the block and i2c_memory_address_pointer_checker.
`timescale 1ns / 100ps

module i2c_memory_address_pointer_tb;
    import i2cmap_pkg::*;

    localparam int RANDOM_ITEMS = 2000;
    localparam int QUIET_CYCLES = 30;
    localparam int TAIL_CYCLES  = 40;
    // covers the clearing sweep after reset several times over
    localparam int STALL_LIMIT  = 300000;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic [1:0]        in_op     = OP_STOP;
    logic [7:0]        in_data   = 8'h00;
    logic              out_stall = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [SIZE_W-1:0] cfg_size  = SIZE_W'(SIZE_MAX);

    logic              o_in_stall;
    logic              o_out_valid;
    logic [7:0]        o_read_data;
    logic              o_cfg_ready;

    int                errors;
    int                pending;
    int                send_idle_pct = 31;
    int                recv_idle_pct = 53;
    int unsigned       words_sent    = 0;
    int unsigned       quiet_count   = 0;
    bit                two_addr      = 1'b1;

    i2c_memory_address_pointer u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (in_op),
        .i_data         (in_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_read_data    (o_read_data),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_mem_size (cfg_size)
    );

    i2c_memory_address_pointer_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (o_in_stall),
        .i_op           (in_op),
        .i_data         (in_data),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .i_read_data    (o_read_data),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_mem_size (cfg_size),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    // 8 ns clock
    initial begin
        forever #4 clk = ~clk;
    end

    // Receiver back-pressure
    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Watchdog on cycles with no word moving on any channel
    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
            (cfg_valid && o_cfg_ready)) begin
            quiet_count <= 0;
        end else if (quiet_count >= STALL_LIMIT) begin
            $display("FAIL i2c_memory_address_pointer");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    // Offer one event word; valid is left high for a back-to-back follower
    task automatic send_event(input t_op op, input logic [7:0] d);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_data  <= d;
        do @(posedge clk); while (o_in_stall);
        words_sent++;
    endtask

    // Hold off until every read byte is out, then let any busy event finish
    task automatic wait_quiet();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // Size write, only with the block idle
    task automatic write_size(input logic [SIZE_W-1:0] v);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_size  <= v;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        two_addr = (v > ONE_BYTE_LIMIT);
    endtask

    // Address bytes for the current mode; high byte often small so reads hit writes
    task automatic send_address();
        if (two_addr)
            send_event(OP_RECV, ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3))
                                                           : 8'($urandom));
        send_event(OP_RECV, 8'($urandom));
    endtask

    initial begin
        int unsigned base;
        int unsigned rel;
        int unsigned next_cfg;
        int unsigned n;
        logic [SIZE_W-1:0] sz;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: read of cleared store, data ignored on non-receive events
        send_event(OP_SEND, 8'hFF);
        send_event(OP_START, 8'hAA);
        send_event(OP_RECV, 8'hFF);
        // request while waiting for the low address byte
        send_event(OP_SEND, 8'h00);
        // low byte added to pointer: top of store, then wrap to zero
        send_event(OP_RECV, 8'hFE);
        send_event(OP_RECV, 8'h5A);
        send_event(OP_RECV, 8'h81);
        send_event(OP_STOP, 8'h55);
        send_event(OP_START, 8'h00);
        send_event(OP_RECV, 8'hFF);
        send_event(OP_RECV, 8'hFF);
        send_event(OP_SEND, 8'h00);
        send_event(OP_SEND, 8'h00);
        // receive in the stopped phase stores at the pointer
        send_event(OP_STOP, 8'h00);
        send_event(OP_RECV, 8'h3C);
        // size shrinks between high and low address byte
        send_event(OP_START, 8'h00);
        send_event(OP_RECV, 8'h00);
        write_size(SIZE_W'(200));
        send_event(OP_RECV, 8'hC8);
        send_event(OP_SEND, 8'h00);
        // size grows after a one-byte start
        send_event(OP_START, 8'h00);
        write_size(SIZE_W'(1000));
        send_event(OP_RECV, 8'hF0);
        send_event(OP_SEND, 8'h00);
        // zero size acts as one byte
        write_size('0);
        send_event(OP_START, 8'h00);
        send_event(OP_RECV, 8'h07);
        send_event(OP_RECV, 8'h33);
        send_event(OP_SEND, 8'h00);
        // all ones clamps to the full store
        write_size('1);
        send_event(OP_START, 8'h00);
        send_event(OP_RECV, 8'h00);
        send_event(OP_RECV, 8'h00);
        send_event(OP_SEND, 8'h00);
        write_size(SIZE_W'(ONE_BYTE_LIMIT));
        send_event(OP_START, 8'h00);
        send_event(OP_RECV, 8'hFF);
        send_event(OP_SEND, 8'h00);
        send_event(OP_STOP, 8'h00);

        // Random transfers across idle modes and sizes
        base     = words_sent;
        next_cfg = base;
        while (words_sent - base < RANDOM_ITEMS) begin
            rel = words_sent - base;
            if (rel >= 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (rel >= RANDOM_ITEMS / 3) begin
                send_idle_pct = 53;
                recv_idle_pct = 31;
            end
            if (words_sent >= next_cfg) begin
                case ($urandom_range(0, 8))
                    0: sz = SIZE_W'(SIZE_MAX);
                    1: sz = SIZE_W'(ONE_BYTE_LIMIT);
                    2: sz = SIZE_W'(ONE_BYTE_LIMIT + 1);
                    3: sz = SIZE_W'(1);
                    4: sz = '0;
                    5: sz = '1;
                    6: sz = SIZE_W'($urandom_range(2, 300));
                    7: sz = SIZE_W'($urandom_range(257, 2000));
                    default: sz = SIZE_W'($urandom_range(1, SIZE_MAX));
                endcase
                write_size(sz);
                next_cfg = words_sent + $urandom_range(100, 200);
            end
            if ($urandom_range(0, 59) == 0)
                wait_quiet();
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    // write transfer
                    send_event(OP_START, 8'($urandom));
                    send_address();
                    n = $urandom_range(1, 8);
                    repeat (n) send_event(OP_RECV, 8'($urandom));
                    if ($urandom_range(0, 9) != 0)
                        send_event(OP_STOP, 8'($urandom));
                end
                5, 6, 7: begin
                    // set address, then read back
                    send_event(OP_START, 8'($urandom));
                    send_address();
                    if ($urandom_range(0, 3) != 0)
                        send_event(OP_STOP, 8'($urandom));
                    n = $urandom_range(1, 8);
                    repeat (n) send_event(OP_SEND, 8'($urandom));
                    send_event(OP_STOP, 8'($urandom));
                end
                8: begin
                    // broken transfer: cut short inside the address
                    send_event(OP_START, 8'($urandom));
                    if (two_addr && $urandom_range(0, 1) != 0)
                        send_event(OP_RECV, 8'($urandom));
                    send_event(($urandom_range(0, 1) != 0) ? OP_SEND : OP_STOP,
                               8'($urandom));
                end
                default: begin
                    // noise
                    n = $urandom_range(1, 4);
                    repeat (n) send_event(t_op'($urandom_range(0, 3)), 8'($urandom));
                end
            endcase
        end

        wait_quiet();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("PASS i2c_memory_address_pointer");
        end else begin
            $display("FAIL i2c_memory_address_pointer");
        end
        $finish;
    end

endmodule
